### src/nmea_rmc_field_extractor_assert.svh
// Assertion macros used by the RMC field extractor top level.
`ifndef NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH
`define NMEA_RMC_FIELD_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NMRMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nmrmc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NMRMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nmrmc: next-cycle check failed");

`endif

### src/nmrmc_pkg.sv
// Types, character codes and field lookup for the RMC field extractor.
package nmrmc_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_G      = 8'h47;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_M      = 8'h4D;
  localparam logic [7:0] CHAR_C      = 8'h43;

  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_LAST = 3'd5;

  localparam logic [2:0] FID_TIME    = 3'd0;
  localparam logic [2:0] FID_STATUS  = 3'd1;
  localparam logic [2:0] FID_LAT     = 3'd2;
  localparam logic [2:0] FID_LAT_HEM = 3'd3;
  localparam logic [2:0] FID_LON     = 3'd4;
  localparam logic [2:0] FID_LON_HEM = 3'd5;
  localparam logic [2:0] FID_DATE    = 3'd6;
  localparam logic [2:0] FID_NONE    = 3'd7;

  localparam int unsigned NUM_FIELDS = 7;
  localparam logic [3:0] COMMA_MAX = 4'd15;

  typedef struct packed {
    logic [2:0] field_id;
    logic [7:0] char_value;
    logic       field_end;
    logic       overflow;
  } rmc_result_t;

  typedef struct packed {
    logic       hit;
    logic       multi;
    logic [2:0] id;
  } field_sel_t;

  // Expected header character at a given match position ("$GPRMC").
  function automatic logic [7:0] header_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd1:    ch = CHAR_G;
      3'd2:    ch = CHAR_P;
      3'd3:    ch = CHAR_R;
      3'd4:    ch = CHAR_M;
      3'd5:    ch = CHAR_C;
      default: ch = CHAR_DOLLAR;
    endcase
    return ch;
  endfunction

  // Field that follows a given number of commas.
  function automatic field_sel_t field_of(input logic [3:0] commas);
    field_sel_t sel;
    sel = '{hit: 1'b1, multi: 1'b0, id: FID_NONE};
    case (commas)
      4'd1:    begin sel.id = FID_TIME;    sel.multi = 1'b1; end
      4'd2:    sel.id = FID_STATUS;
      4'd3:    begin sel.id = FID_LAT;     sel.multi = 1'b1; end
      4'd4:    sel.id = FID_LAT_HEM;
      4'd5:    begin sel.id = FID_LON;     sel.multi = 1'b1; end
      4'd6:    sel.id = FID_LON_HEM;
      4'd9:    begin sel.id = FID_DATE;    sel.multi = 1'b1; end
      default: sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

endpackage

### src/nmrmc_parser.sv
// Sentence parse state and per-character result logic of the RMC extractor.
module nmrmc_parser #(
  parameter int unsigned MAX_FIELD_CHARS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [7:0]                  rx_byte,
  input  logic [6:0]                  enable_mask,
  output logic                        res_valid,
  output nmrmc_pkg::rmc_result_t      res
);
  import nmrmc_pkg::*;

  localparam int unsigned CW = $clog2(MAX_FIELD_CHARS + 1);
  localparam logic [CW-1:0] CHAR_LIMIT = CW'(MAX_FIELD_CHARS);

  logic [2:0]    header_index_r, header_index_nxt;
  logic          in_rmc_r, in_rmc_nxt;
  logic [3:0]    comma_count_r, comma_count_nxt;
  logic [CW-1:0] chars_in_field_r, chars_in_field_nxt;
  logic          field_overflowed_r, field_overflowed_nxt;

  field_sel_t sel;
  logic       sel_enabled;

  assign sel = field_of(comma_count_r);
  assign sel_enabled = sel.hit && enable_mask[sel.id];

  always_comb begin
    header_index_nxt     = header_index_r;
    in_rmc_nxt           = in_rmc_r;
    comma_count_nxt      = comma_count_r;
    chars_in_field_nxt   = chars_in_field_r;
    field_overflowed_nxt = field_overflowed_r;
    res_valid            = 1'b0;
    res                  = '{field_id: sel.id, char_value: rx_byte,
                             field_end: 1'b0, overflow: 1'b0};

    if (rx_byte == CHAR_DOLLAR || rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
      // Any sentence boundary drops the open field without an end marker.
      in_rmc_nxt           = 1'b0;
      comma_count_nxt      = '0;
      chars_in_field_nxt   = '0;
      field_overflowed_nxt = 1'b0;
      header_index_nxt     = (rx_byte == CHAR_DOLLAR) ? 3'd1 : HDR_IDLE;
    end else if (header_index_r != HDR_IDLE && header_index_r <= HDR_LAST) begin
      if (rx_byte == header_char(header_index_r)) begin
        if (header_index_r == HDR_LAST) begin
          header_index_nxt     = HDR_IDLE;
          in_rmc_nxt           = 1'b1;
          comma_count_nxt      = '0;
          chars_in_field_nxt   = '0;
          field_overflowed_nxt = 1'b0;
        end else begin
          header_index_nxt = header_index_r + 3'd1;
        end
      end else begin
        header_index_nxt = HDR_IDLE;
      end
    end else begin
      header_index_nxt = HDR_IDLE;
      if (in_rmc_r) begin
        if (rx_byte == CHAR_COMMA) begin
          // The closing comma of an enabled multi-character field emits its end marker.
          if (sel.multi && sel_enabled) begin
            res_valid      = 1'b1;
            res.char_value = '0;
            res.field_end  = 1'b1;
            res.overflow   = field_overflowed_r;
          end
          if (comma_count_r != COMMA_MAX) begin
            comma_count_nxt = comma_count_r + 4'd1;
          end
          chars_in_field_nxt   = '0;
          field_overflowed_nxt = 1'b0;
        end else if (sel.hit) begin
          if (sel.multi) begin
            if (chars_in_field_r < CHAR_LIMIT) begin
              chars_in_field_nxt = chars_in_field_r + CW'(1);
              res_valid          = sel_enabled;
            end else begin
              field_overflowed_nxt = 1'b1;
            end
          end else if (chars_in_field_r == '0) begin
            // A single-character field closes on its only character.
            chars_in_field_nxt = CW'(1);
            res_valid          = sel_enabled;
            res.field_end      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_index_r     <= HDR_IDLE;
      in_rmc_r           <= 1'b0;
      comma_count_r      <= '0;
      chars_in_field_r   <= '0;
      field_overflowed_r <= 1'b0;
    end else if (step_en) begin
      header_index_r     <= header_index_nxt;
      in_rmc_r           <= in_rmc_nxt;
      comma_count_r      <= comma_count_nxt;
      chars_in_field_r   <= chars_in_field_nxt;
      field_overflowed_r <= field_overflowed_nxt;
    end
  end

endmodule

### src/nmrmc_out_buf.sv
// Result register with a skid entry so input and output stall independently.
module nmrmc_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  nmrmc_pkg::rmc_result_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output nmrmc_pkg::rmc_result_t out_data
);
  import nmrmc_pkg::*;

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  rmc_result_t main_r, main_nxt;
  rmc_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop       = main_valid_r && out_ready;
  assign can_push  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (pop || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

### src/nmea_rmc_field_extractor.sv
// Top level of the NMEA RMC field extractor: parser, result buffer and mask register.
// Throughput: one character per cycle while in_ready is high; each request is parsed in the
// cycle it is accepted. A result is registered in the buffer's main entry, or in its skid
// entry while the output stalls, before it shows on out_valid. The buffer has two entries;
// in_ready drops only while both of them hold results that the consumer has not taken.
// Reset (synchronous, rst_n low) clears the parse state and buffer, and sets the mask to all ones.
module nmea_rmc_field_extractor #(
  parameter int unsigned MAX_FIELD_CHARS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_field_id,
  output logic [7:0] out_char_value,
  output logic       out_field_end,
  output logic       out_overflow,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);
  import nmrmc_pkg::*;

  `include "nmea_rmc_field_extractor_assert.svh"

  // Field enable mask: bit f passes field id f. The user writes it only while idle; not enforced.
  logic [6:0] field_enable_mask_r;

  logic        in_accept;
  logic        res_valid;
  rmc_result_t res;
  rmc_result_t out_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_enable_mask_r <= {NUM_FIELDS{1'b1}};
    end else if (cfg_wr_en) begin
      field_enable_mask_r <= cfg_wr_data;
    end
  end

  // A request is accepted whenever the result buffer has a free entry, so the
  // parse state advances every cycle that a character is accepted.
  assign in_accept = in_valid && in_ready;

  nmrmc_parser #(
    .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_accept),
    .rx_byte    (in_rx_byte),
    .enable_mask(field_enable_mask_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // The buffer takes a result only for a character that produced one; a
  // character that produces nothing still advances the parse state.
  nmrmc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_accept && res_valid),
    .push_data(res),
    .can_push (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign out_field_id   = out_data.field_id;
  assign out_char_value = out_data.char_value;
  assign out_field_end  = out_data.field_end;
  assign out_overflow   = out_data.overflow;

  // A full buffer always shows a result at the output.
  `NMRMC_ASSERT_NOW(a_full_shows_result, clk, rst_n, !in_ready, out_valid)
  // Overflow is only reported on an end marker, which carries a zero character.
  `NMRMC_ASSERT_NOW(a_overflow_on_marker, clk, rst_n, out_valid && out_overflow,
                    out_field_end && out_char_value == 8'd0)
  // Every delivered result names a real field.
  `NMRMC_ASSERT_NOW(a_valid_field_id, clk, rst_n, out_valid, out_field_id != FID_NONE)
  // A result pushed while the output stalls lands in the skid entry.
  `NMRMC_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n,
                     in_accept && res_valid && out_valid && !out_ready, !in_ready)

endmodule
